[design/csat_pkg.sv]
package csat_pkg;

   localparam int VW = 16;   // stored coordinate width
   localparam int DW = 17;   // edge and turn vector component
   localparam int PW = 33;   // coordinate times edge component, and their differences
   localparam int TW = 34;   // turn perp-dot

   typedef struct packed {
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] x;
   } vert_type;

   // one edge travelling down the cell row, carrying its running minimum
   typedef struct packed {
      logic                 valid;
      logic                 qsel;   // polygon whose vertices are projected: 0 = A, 1 = B
      logic signed [DW-1:0] ex;
      logic signed [DW-1:0] ey;
      logic signed [PW-1:0] reach;
      logic signed [PW-1:0] least;
   } edge_type;

   typedef struct packed {
      logic     head;     // first cell of the row starts the minimum
      logic     load_a;
      logic     load_b;
      logic     live_a;   // this cell holds a vertex of A in the current pair
      logic     live_b;
      vert_type vert;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_DONE
   } fsm_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_EMPTY,
      ST_A_NOT_CCW,
      ST_B_NOT_CCW,
      ST_OVERFLOW
   } status_type;

endpackage

[design/csat_cell.sv]
module csat_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  csat_pkg::cell_ctl_type ctl,
   input  csat_pkg::edge_type    edge_in,
   output csat_pkg::edge_type    edge_out
);
   import csat_pkg::*;

   vert_type             a_ff;
   vert_type             b_ff;
   vert_type             q;
   edge_type             mid_ff;
   edge_type             out_ff;
   edge_type             out_in;
   logic signed [PW-1:0] px_ff;
   logic signed [PW-1:0] py_ff;
   logic signed [PW-1:0] d;
   logic                 live;

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         a_ff <= ctl.vert;
      end
      if (ctl.load_b) begin
         b_ff <= ctl.vert;
      end
   end

   assign q = edge_in.qsel ? b_ff : a_ff;

   always_comb begin
      d      = px_ff - py_ff;
      live   = mid_ff.qsel ? ctl.live_b : ctl.live_a;
      out_in = mid_ff;
      if (ctl.head || (live && (d < mid_ff.least))) begin
         out_in.least = d;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= PW'(q.x) * PW'(edge_in.ey);
      py_ff <= PW'(q.y) * PW'(edge_in.ex);
      if (reset) begin
         mid_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         mid_ff <= edge_in;
         out_ff <= out_in;
      end
   end

   assign edge_out = out_ff;

endmodule

[design/convex_polygon_sat_overlap.sv]
// channel  dir  tdata                              tuser           tlast
// req      in   [15:0] vertex_x, [31:16] vertex_y  polygon_select  last_vertex
// rsp      out  [0] overlap, [3:1] status, pad     -               -
// csr      in   csr_wdata = winding_tolerance, written when csr_we is high
//
// vertex beats are taken one per cycle while idle; the beat carrying tlast starts the test
// the test walks one edge per cycle out of the vertex stores, and each edge crosses the row
// of MAX_VERTICES cells; too many vertices or an empty polygon skip the walk and go straight to the result
// a waiting result does not block loading of the next pair, only the end of its test
// reset clears counts and control; vertex stores need no clearing
module convex_polygon_sat_overlap #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // vertex_x, vertex_y
   input  logic        req_tuser,    // polygon_select
   input  logic        req_tlast,    // last_vertex
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // overlap, status
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import csat_pkg::*;

   localparam int IW        = $clog2(MAX_VERTICES);
   localparam int CW        = $clog2(MAX_VERTICES + 1);
   localparam int SW        = $clog2(MAX_VERTICES + 2);
   localparam int CB        = (COORD_BITS < 16) ? COORD_BITS : 16;
   localparam int SH        = 16 - CB;
   localparam int DRAIN_CYC = 2 * MAX_VERTICES + 6;
   localparam int DCW       = $clog2(DRAIN_CYC + 1);

   fsm_type    state_ff, state_in;
   logic [31:0] tol_ff;
   logic [CW-1:0] cnt_a_ff, cnt_b_ff, cnt_a_nx, cnt_b_nx;
   logic       ovf_ff, ovf_nx;
   vert_type   store_a [MAX_VERTICES];
   vert_type   store_b [MAX_VERTICES];
   vert_type   rd_a_ff, rd_b_ff;
   vert_type   in_vert;
   logic       acc, full_sel, wr_a, wr_b;

   // control from the state machine
   logic       issue, start_walk, switch_poly, start_drain, res_load, deliver;
   status_type res_stat_in, res_stat_ff, rsp_stat_ff;
   logic       res_ovl_in, res_ovl_ff, rsp_ovl_ff, rsp_valid_ff;

   logic          walk_sel_ff;
   logic [SW-1:0] step_ff;
   logic [CW-1:0] n;
   logic [SW-1:0] addr_w;
   logic [IW-1:0] rd_addr;
   logic          last_step;
   logic [DCW-1:0] drain_ff;

   logic       rd_v_ff, rd_real_ff, rd_sel_ff;
   vert_type   dat, w1_ff, w2_ff, cur_ff;
   logic       s1_v_ff, s1_sel_ff, s2_v_ff, s2_sel_ff;
   logic signed [DW-1:0] ux_ff, uy_ff, vx_ff, vy_ff, ex_ff, ey_ff, ex2_ff, ey2_ff;
   logic signed [TW-1:0] t1_ff, t2_ff, turn;
   logic signed [PW-1:0] r1_ff, r2_ff;
   logic signed [TW:0]   slack;
   logic       bad_a_ff, bad_b_ff, sep_ff;
   edge_type   ch_ff;
   edge_type   links [MAX_VERTICES + 1];
   edge_type   tail;

   // input side
   assign req_tready = (state_ff == S_IDLE);
   assign acc      = req_tvalid & req_tready;
   assign in_vert.x = $signed(req_tdata[15:0] << SH) >>> SH;
   assign in_vert.y = $signed(req_tdata[31:16] << SH) >>> SH;
   assign full_sel = req_tuser ? (cnt_b_ff == CW'(MAX_VERTICES))
                               : (cnt_a_ff == CW'(MAX_VERTICES));
   assign wr_a     = acc & ~req_tuser & ~full_sel;
   assign wr_b     = acc & req_tuser & ~full_sel;
   assign cnt_a_nx = cnt_a_ff + CW'(wr_a);
   assign cnt_b_nx = cnt_b_ff + CW'(wr_b);
   assign ovf_nx   = ovf_ff | (acc & full_sel);

   // walk address: two previous vertices first, then the polygon in order
   always_comb begin
      n = walk_sel_ff ? cnt_b_ff : cnt_a_ff;
      if (step_ff == SW'(0)) begin
         addr_w = (n >= CW'(2)) ? SW'(n) - SW'(2) : SW'(0);
      end else if (step_ff == SW'(1)) begin
         addr_w = SW'(n) - SW'(1);
      end else begin
         addr_w = step_ff - SW'(2);
      end
      rd_addr   = addr_w[IW-1:0];
      last_step = (step_ff == SW'(n) + SW'(1));
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a[cnt_a_ff[IW-1:0]] <= in_vert;
      end
      if (wr_b) begin
         store_b[cnt_b_ff[IW-1:0]] <= in_vert;
      end
      rd_a_ff <= store_a[rd_addr];
      rd_b_ff <= store_b[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      issue       = 1'b0;
      start_walk  = 1'b0;
      switch_poly = 1'b0;
      start_drain = 1'b0;
      res_load    = 1'b0;
      res_stat_in = ST_OK;
      res_ovl_in  = 1'b0;
      deliver     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (acc && req_tlast) begin
               if (ovf_nx) begin
                  res_load    = 1'b1;
                  res_stat_in = ST_OVERFLOW;
                  state_in    = S_DONE;
               end else if (cnt_a_nx == CW'(0) || cnt_b_nx == CW'(0)) begin
                  res_load    = 1'b1;
                  res_stat_in = ST_EMPTY;
                  state_in    = S_DONE;
               end else begin
                  start_walk = 1'b1;
                  state_in   = S_WALK;
               end
            end
         end
         S_WALK: begin
            issue = 1'b1;
            if (last_step) begin
               if (walk_sel_ff) begin
                  start_drain = 1'b1;
                  state_in    = S_DRAIN;
               end else begin
                  switch_poly = 1'b1;
               end
            end
         end
         S_DRAIN: begin
            if (drain_ff == DCW'(0)) begin
               res_load = 1'b1;
               priority if (bad_a_ff) begin
                  res_stat_in = ST_A_NOT_CCW;
               end else if (bad_b_ff) begin
                  res_stat_in = ST_B_NOT_CCW;
               end else begin
                  res_stat_in = ST_OK;
                  res_ovl_in  = ~sep_ff;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               deliver  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= '0;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         walk_sel_ff  <= 1'b0;
         step_ff      <= '0;
         drain_ff     <= '0;
         rd_v_ff      <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         bad_a_ff     <= 1'b0;
         bad_b_ff     <= 1'b0;
         sep_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            tol_ff <= csr_wdata;
         end
         if (deliver) begin
            cnt_a_ff <= '0;
            cnt_b_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            cnt_a_ff <= cnt_a_nx;
            cnt_b_ff <= cnt_b_nx;
            ovf_ff   <= ovf_nx;
         end
         if (start_walk) begin
            walk_sel_ff <= 1'b0;
            step_ff     <= '0;
         end else if (switch_poly) begin
            walk_sel_ff <= 1'b1;
            step_ff     <= '0;
         end else if (issue) begin
            step_ff <= step_ff + SW'(1);
         end
         if (start_drain) begin
            drain_ff <= DCW'(DRAIN_CYC);
         end else if (drain_ff != DCW'(0)) begin
            drain_ff <= drain_ff - DCW'(1);
         end
         rd_v_ff     <= issue;
         s1_v_ff     <= rd_v_ff & rd_real_ff;
         s2_v_ff     <= s1_v_ff;
         if (start_walk) begin
            bad_a_ff <= 1'b0;
            bad_b_ff <= 1'b0;
            sep_ff   <= 1'b0;
         end else begin
            if (s2_v_ff && slack[TW]) begin
               if (s2_sel_ff) begin
                  bad_b_ff <= 1'b1;
               end else begin
                  bad_a_ff <= 1'b1;
               end
            end
            if (tail.valid && (tail.least > tail.reach)) begin
               sep_ff <= 1'b1;
            end
         end
         if (deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // vertex window and edge pipeline
   assign dat   = rd_sel_ff ? rd_b_ff : rd_a_ff;
   assign turn  = t1_ff - t2_ff;
   assign slack = (TW + 1)'(turn) + (TW + 1)'(tol_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff.valid <= 1'b0;
      end else begin
         ch_ff.valid <= s2_v_ff;
      end
      rd_real_ff <= (step_ff >= SW'(2));
      rd_sel_ff  <= walk_sel_ff;
      if (rd_v_ff) begin
         w1_ff <= dat;
         w2_ff <= w1_ff;
      end
      s1_sel_ff <= rd_sel_ff;
      cur_ff    <= dat;
      ux_ff     <= DW'(w1_ff.x) - DW'(w2_ff.x);
      uy_ff     <= DW'(w1_ff.y) - DW'(w2_ff.y);
      vx_ff     <= DW'(dat.x) - DW'(w2_ff.x);
      vy_ff     <= DW'(dat.y) - DW'(w2_ff.y);
      ex_ff     <= DW'(dat.x) - DW'(w1_ff.x);
      ey_ff     <= DW'(dat.y) - DW'(w1_ff.y);
      s2_sel_ff <= s1_sel_ff;
      t1_ff     <= TW'(ux_ff) * TW'(vy_ff);
      t2_ff     <= TW'(uy_ff) * TW'(vx_ff);
      r1_ff     <= PW'(cur_ff.x) * PW'(ey_ff);
      r2_ff     <= PW'(cur_ff.y) * PW'(ex_ff);
      ex2_ff    <= ex_ff;
      ey2_ff    <= ey_ff;
      ch_ff.qsel  <= ~s2_sel_ff;
      ch_ff.ex    <= ex2_ff;
      ch_ff.ey    <= ey2_ff;
      ch_ff.reach <= r1_ff - r2_ff;
      ch_ff.least <= '0;
      if (res_load) begin
         res_stat_ff <= res_stat_in;
         res_ovl_ff  <= res_ovl_in;
      end
      if (deliver) begin
         rsp_stat_ff <= res_stat_ff;
         rsp_ovl_ff  <= res_ovl_ff;
      end
   end

   // row of cells, one vertex of each polygon per cell
   assign links[0] = ch_ff;

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      cell_ctl_type ctl;
      assign ctl.head   = (k == 0);
      assign ctl.load_a = wr_a && (cnt_a_ff[IW-1:0] == IW'(k));
      assign ctl.load_b = wr_b && (cnt_b_ff[IW-1:0] == IW'(k));
      assign ctl.live_a = (cnt_a_ff > CW'(k));
      assign ctl.live_b = (cnt_b_ff > CW'(k));
      assign ctl.vert   = in_vert;

      csat_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .edge_in  (links[k]),
         .edge_out (links[k + 1])
      );
   end

   assign tail = links[MAX_VERTICES];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_stat_ff, rsp_ovl_ff};

   a_count_a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_a_ff <= CW'(MAX_VERTICES))
      else $error("vertex count of A beyond store depth");

   a_count_b_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_b_ff <= CW'(MAX_VERTICES))
      else $error("vertex count of B beyond store depth");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (cnt_a_ff != CW'(0) && cnt_b_ff != CW'(0)))
      else $error("edge walk started on an empty polygon");

   a_row_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> !tail.valid)
      else $error("edge still in cell row when result is taken");

endmodule
